// ----- rtl/dvn_pkg.sv -----
// Package for the distance-vector node update block.
// Holds widths, cost constants, register and opcode codes, shared types and
// the cost saturation function. No dependencies.
`default_nettype none

package dvn_pkg;

    localparam int NUM_NODES   = 4;
    localparam int NODE_W      = 2;
    localparam int COST_W      = 10;
    localparam int CFG_ADDR_W  = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int PKT_CNT_W   = 2;

    typedef logic [NODE_W-1:0]               node_t;
    typedef logic [COST_W-1:0]               cost_t;
    typedef cost_t [NUM_NODES-1:0]           cost_vec_t;
    typedef logic [CFG_ADDR_W-1:0]           cfg_addr_t;

    localparam cost_t COST_INF = cost_t'(999);

    localparam cost_vec_t LINK_RESET = {cost_t'(2), cost_t'(0), cost_t'(1), cost_t'(3)};
    localparam node_t     SELF_RESET = node_t'(2);

    localparam cfg_addr_t REG_SELF_ID  = cfg_addr_t'(0);
    localparam cfg_addr_t REG_LINK_N0  = cfg_addr_t'(1);
    localparam cfg_addr_t REG_LINK_N1  = cfg_addr_t'(2);
    localparam cfg_addr_t REG_LINK_N2  = cfg_addr_t'(3);
    localparam cfg_addr_t REG_LINK_N3  = cfg_addr_t'(4);

    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic  load;
        logic  init;
        node_t sender;
        cost_t hop;
    } lane_ctl_t;

    typedef struct packed {
        logic      start;
        node_t     src;
        cost_vec_t mins;
    } adv_req_t;

    function automatic cost_t sat_cost(input logic [COST_W:0] v);
        cost_t r;
        if (v < {1'b0, COST_INF})
        begin
            r = v[COST_W-1:0];
        end
        else
        begin
            r = COST_INF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dvn_lane.sv -----
// One destination row of the distance table with its update and row minimum.
// Depends on dvn_pkg.
`default_nettype none

module dvn_lane (
    input  wire                  clk,
    input  wire                  rst_n,
    input  dvn_pkg::node_t       lane_id,
    input  dvn_pkg::lane_ctl_t   ctl,
    input  dvn_pkg::cost_t       link_cost,
    input  dvn_pkg::cost_t       adv_cost,
    output dvn_pkg::cost_t       diag,
    output dvn_pkg::cost_t       row_min
);
    import dvn_pkg::*;

    cost_vec_t row_reg;
    cost_vec_t row_next;
    cost_vec_t row_init;
    cost_t     min_lo;
    cost_t     min_hi;

    always_comb
    begin
        for (int v = 0; v < NUM_NODES; v++)
        begin
            row_init[v] = (node_t'(v) == lane_id) ? sat_cost({1'b0, link_cost}) : COST_INF;
        end
    end

    always_comb
    begin
        row_next = row_reg;
        if (ctl.load)
        begin
            if (ctl.init)
            begin
                row_next = row_init;
            end
            else
            begin
                row_next[ctl.sender] = sat_cost({1'b0, ctl.hop} + {1'b0, adv_cost});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NUM_NODES; v++)
            begin
                row_reg[v] <= (node_t'(v) == lane_id) ? LINK_RESET[lane_id] : COST_INF;
            end
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign diag    = row_reg[lane_id];
    assign min_lo  = (row_reg[1] < row_reg[0]) ? row_reg[1] : row_reg[0];
    assign min_hi  = (row_reg[3] < row_reg[2]) ? row_reg[3] : row_reg[2];
    assign row_min = (min_hi < min_lo) ? min_hi : min_lo;

endmodule

`default_nettype wire

// ----- rtl/dvn_merge.sv -----
// Merge of the lane minima: holds the current minimum-cost vector and flags
// a change. Depends on dvn_pkg.
`default_nettype none

module dvn_merge (
    input  wire                  clk,
    input  wire                  rst_n,
    input  dvn_pkg::cost_vec_t   lane_min,
    input  wire                  commit,
    output logic                 changed
);
    import dvn_pkg::*;

    cost_vec_t min_vec_reg;
    cost_vec_t min_vec_next;

    always_comb
    begin
        changed = 1'b0;
        for (int d = 0; d < NUM_NODES; d++)
        begin
            if (lane_min[d] != min_vec_reg[d])
            begin
                changed = 1'b1;
            end
        end
    end

    assign min_vec_next = commit ? lane_min : min_vec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_vec_reg <= '0;
        end
        else
        begin
            min_vec_reg <= min_vec_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dvn_adv.sv -----
// Advertisement sequencer and output register: one packet per node other
// than the source, in increasing node order. Depends on dvn_pkg.
`default_nettype none

module dvn_adv (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  dvn_pkg::adv_req_t                     req,
    output logic                                  idle,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // src_node[1:0], dst_node[3:2], min_cost_0..3[43:4], zero[47:44]
    output logic [dvn_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import dvn_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - 2 * NODE_W - NUM_NODES * COST_W;
    localparam logic [PKT_CNT_W-1:0] LAST_CNT = PKT_CNT_W'(NUM_NODES - 2);

    logic                 valid_reg;
    logic                 valid_next;
    logic [PKT_CNT_W-1:0] cnt_reg;
    logic [PKT_CNT_W-1:0] cnt_next;
    node_t                src_reg;
    node_t                src_next;
    node_t                dst_reg;
    node_t                dst_next;
    cost_vec_t            mins_reg;
    cost_vec_t            mins_next;
    logic                 last;
    logic                 fire;

    function automatic node_t step_dst(input node_t dst, input node_t self_id);
        node_t n;
        n = node_t'(dst + node_t'(1));
        if (n == self_id)
        begin
            n = node_t'(dst + node_t'(2));
        end
        return n;
    endfunction

    assign last = (cnt_reg == LAST_CNT);
    assign fire = valid_reg && m_axis_tready;
    assign idle = !valid_reg || (fire && last);

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        mins_next  = mins_reg;
        priority if (req.start && idle)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
            src_next   = req.src;
            dst_next   = (req.src == node_t'(0)) ? node_t'(1) : node_t'(0);
            mins_next  = req.mins;
        end
        else if (fire && last)
        begin
            valid_next = 1'b0;
        end
        else if (fire)
        begin
            cnt_next = cnt_reg + PKT_CNT_W'(1);
            dst_next = step_dst(dst_reg, src_reg);
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        mins_reg <= mins_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = last;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, mins_reg, dst_reg, src_reg};

endmodule

`default_nettype wire

// ----- rtl/distance_vector_node_update_unit.sv -----
// Top level of the distance-vector node update block: configuration
// registers, four table lanes, minimum merge and advertisement sequencer.
// Depends on dvn_pkg, dvn_lane, dvn_merge, dvn_adv.
//
//   channel  | direction | handshake               | content
//   s_axis   | in        | s_axis_tvalid/tready    | tuser opcode, tdata sender and costs
//   m_axis   | out       | m_axis_tvalid/tready    | tdata packet, tlast last packet
//   cfg      | in        | cfg_wr_en               | cfg_addr register, cfg_wdata value
//
// An item updates the four table rows at its accept edge; the next cycle
// merges the row minima and hands the packets to the output register.
// The block takes no new item while one waits in the merge state, and packets
// leave one per cycle while m_axis_tready is high, three per advertisement.
// A busy sequencer holds the merge state of an advertising item until it is free.
// Reset loads the table from the reset link costs and clears the minima.
`default_nettype none

module distance_vector_node_update_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // sender_node[1:0], adv_cost_0..3[41:2], zero[47:42]
    input  wire  [dvn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // opcode[0]
    input  wire                                 s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // src_node[1:0], dst_node[3:2], min_cost_0..3[43:4], zero[47:44]
    output logic [dvn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  wire                                 cfg_wr_en,
    input  wire  [dvn_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [dvn_pkg::COST_W-1:0]          cfg_wdata
);
    import dvn_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic      state_reg;
    logic      state_next;
    logic      init_reg;
    logic      init_next;
    node_t     self_id_reg;
    cost_vec_t link_cost_reg;

    logic      in_fire;
    node_t     sender;
    cost_vec_t adv_cost;
    cost_vec_t lane_diag;
    cost_vec_t lane_min;
    lane_ctl_t lane_ctl;
    logic      changed;
    logic      do_adv;
    logic      adv_idle;
    logic      commit;
    adv_req_t  adv_req;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign sender        = s_axis_tdata[NODE_W-1:0];
    assign adv_cost      = s_axis_tdata[NODE_W + NUM_NODES*COST_W - 1:NODE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg   <= SELF_RESET;
            link_cost_reg <= LINK_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SELF_ID: self_id_reg      <= cfg_wdata[NODE_W-1:0];
                REG_LINK_N0: link_cost_reg[0] <= cfg_wdata;
                REG_LINK_N1: link_cost_reg[1] <= cfg_wdata;
                REG_LINK_N2: link_cost_reg[2] <= cfg_wdata;
                REG_LINK_N3: link_cost_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign lane_ctl.load   = in_fire;
    assign lane_ctl.init   = (s_axis_tuser == OP_INIT);
    assign lane_ctl.sender = sender;
    assign lane_ctl.hop    = lane_diag[sender];

    for (genvar g = 0; g < NUM_NODES; g++)
    begin : g_lane
        dvn_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .lane_id   (node_t'(g)),
            .ctl       (lane_ctl),
            .link_cost (link_cost_reg[g]),
            .adv_cost  (adv_cost[g]),
            .diag      (lane_diag[g]),
            .row_min   (lane_min[g])
        );
    end

    assign do_adv = init_reg || changed;
    assign commit = (state_reg == ST_MERGE) && (!do_adv || adv_idle);

    dvn_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .lane_min (lane_min),
        .commit   (commit),
        .changed  (changed)
    );

    assign adv_req.start = commit && do_adv;
    assign adv_req.src   = self_id_reg;
    assign adv_req.mins  = lane_min;

    dvn_adv u_adv (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (adv_req),
        .idle          (adv_idle),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_MERGE;
                    init_next  = (s_axis_tuser == OP_INIT);
                end
            end
            ST_MERGE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            init_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
        end
    end

    a_accept_to_merge: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_MERGE))
        else $error("accepted item did not enter merge");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        adv_req.start |-> adv_idle)
        else $error("advertisement started while sequencer busy");

    a_no_self_packet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2*NODE_W-1:NODE_W] != m_axis_tdata[NODE_W-1:0]))
        else $error("packet addressed to its own source");

    a_init_advertises: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && init_reg) |-> adv_req.start)
        else $error("init item without advertisement");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for distance_vector_node_update_unit: routing-table predictor,
// directed and random advertisement items, random stalls on both streams.
// Depends on dvn_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
    import dvn_pkg::*;

    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int NUM_DIRECTED   = 16;

    localparam cfg_addr_t REG_SPARE = cfg_addr_t'(5);

    typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE} sink_mode_e;

    typedef struct packed {
        node_t     src;
        node_t     dst;
        cost_vec_t mins;
        logic      last;
    } route_pkt_t;

    typedef struct packed {
        logic      op;
        node_t     snd;
        cost_vec_t adv;
        logic      typed;
        logic      typed_adv;
        cost_vec_t typed_mins;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_wr_en;
    cfg_addr_t cfg_addr;
    logic [COST_W-1:0] cfg_wdata;

    node_t      self_node;
    cost_t      link_cost_q [NUM_NODES];
    cost_t      route_tbl [NUM_NODES][NUM_NODES];
    cost_vec_t  route_min;
    route_pkt_t adverts_due [$];
    int         err_count = 0;
    int         quiet_cycles = 0;
    bit         hold_req = 1'b0;

    always #4 clk = ~clk;

    distance_vector_node_update_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    function automatic cost_vec_t costs4(int c0, int c1, int c2, int c3);
        return {cost_t'(c3), cost_t'(c2), cost_t'(c1), cost_t'(c0)};
    endfunction

    function automatic cost_t cap_cost(int v);
        return (v < int'(COST_INF)) ? cost_t'(v) : COST_INF;
    endfunction

    function automatic void reload_routes();
        for (int d = 0; d < NUM_NODES; d++)
        begin
            for (int v = 0; v < NUM_NODES; v++)
            begin
                route_tbl[d][v] = (d == v) ? cap_cost(int'(link_cost_q[d])) : COST_INF;
            end
        end
    endfunction

    function automatic logic refresh_minima();
        logic  changed;
        cost_t m;
        changed = 1'b0;
        for (int d = 0; d < NUM_NODES; d++)
        begin
            m = route_tbl[d][0];
            for (int v = 1; v < NUM_NODES; v++)
            begin
                if (route_tbl[d][v] < m)
                begin
                    m = route_tbl[d][v];
                end
            end
            if (m != route_min[d])
            begin
                changed = 1'b1;
            end
            route_min[d] = m;
        end
        return changed;
    endfunction

    // returns 1 when the item triggers an advertisement
    function automatic logic update_routes(logic op, node_t snd, cost_vec_t adv);
        cost_t hop;
        if (op == OP_INIT)
        begin
            reload_routes();
            void'(refresh_minima());
            return 1'b1;
        end
        hop = route_tbl[snd][snd];
        for (int d = 0; d < NUM_NODES; d++)
        begin
            route_tbl[d][snd] = cap_cost(int'(hop) + int'(adv[d]));
        end
        return refresh_minima();
    endfunction

    function automatic void queue_adverts(cost_vec_t mins);
        route_pkt_t p;
        int         last_dst;
        last_dst = (self_node == node_t'(NUM_NODES - 1)) ? NUM_NODES - 2 : NUM_NODES - 1;
        for (int n = 0; n < NUM_NODES; n++)
        begin
            if (node_t'(n) != self_node)
            begin
                p.src  = self_node;
                p.dst  = node_t'(n);
                p.mins = mins;
                p.last = (n == last_dst);
                adverts_due.push_back(p);
            end
        end
    endfunction

    task automatic send_item(logic op, node_t snd, cost_vec_t adv, logic typed,
                             logic typed_adv, cost_vec_t typed_mins);
        logic adv_out;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, adv, snd};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        adv_out = update_routes(op, snd, adv);
        if (typed)
        begin
            if (typed_adv)
            begin
                queue_adverts(typed_mins);
            end
        end
        else if (adv_out)
        begin
            queue_adverts(route_min);
        end
    endtask

    task automatic wait_routes_idle();
        s_axis_tvalid <= 1'b0;
        while (adverts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_node(node_t id, cost_vec_t links);
        cfg_addr_t link_regs [NUM_NODES];
        link_regs = '{REG_LINK_N0, REG_LINK_N1, REG_LINK_N2, REG_LINK_N3};
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_SELF_ID;
        cfg_wdata <= {8'($urandom_range(255)), id};
        @(posedge clk);
        self_node = id;
        for (int k = 0; k < NUM_NODES; k++)
        begin
            cfg_addr  <= link_regs[k];
            cfg_wdata <= links[k];
            @(posedge clk);
            link_cost_q[k] = links[k];
        end
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= COST_W'($urandom_range(1023));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        dir_row_t  dir_rows [NUM_DIRECTED];
        cost_vec_t adv;
        cost_vec_t links;
        logic      op;
        int        burst_left;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_SELF_ID;
        cfg_wdata     = '0;

        self_node = SELF_RESET;
        for (int k = 0; k < NUM_NODES; k++)
        begin
            link_cost_q[k] = LINK_RESET[k];
        end
        reload_routes();
        route_min = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            '{OP_INIT,   node_t'(3), costs4(1023, 1023, 1023, 1023), 1'b1, 1'b1, LINK_RESET},
            '{OP_UPDATE, node_t'(2), costs4(999, 999, 0, 999),       1'b1, 1'b0, '0},
            '{OP_UPDATE, node_t'(0), costs4(0, 0, 0, 0),             1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(1), costs4(1023, 1023, 1023, 1023), 1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(3), costs4(341, 682, 341, 682),     1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(3), costs4(682, 341, 682, 341),     1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(2), costs4(998, 999, 1000, 0),      1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(0), costs4(996, 995, 994, 1),       1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(1), costs4(1, 2, 3, 4),             1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(1), costs4(1, 2, 3, 4),             1'b0, 1'b0, '0},
            '{OP_INIT,   node_t'(0), costs4(0, 0, 0, 0),             1'b1, 1'b1, LINK_RESET},
            '{OP_INIT,   node_t'(1), costs4(512, 256, 128, 64),      1'b1, 1'b1, LINK_RESET},
            '{OP_UPDATE, node_t'(0), costs4(0, 5, 5, 5),             1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(3), costs4(0, 0, 0, 0),             1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(2), costs4(1023, 1023, 1023, 1023), 1'b0, 1'b0, '0},
            '{OP_UPDATE, node_t'(1), costs4(0, 0, 0, 0),             1'b0, 1'b0, '0}
        };

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].op, dir_rows[i].snd, dir_rows[i].adv, dir_rows[i].typed,
                      dir_rows[i].typed_adv, dir_rows[i].typed_mins);
            if ($urandom_range(3) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end

        for (int ph = 1; ph <= NUM_PHASES; ph++)
        begin
            wait_routes_idle();
            case (ph)
                1: program_node(node_t'(0), costs4(0, 0, 0, 0));
                2: program_node(node_t'(3), costs4(999, 999, 999, 999));
                3: program_node(node_t'(1), costs4(1023, 1000, 0, 512));
                default:
                begin
                    for (int k = 0; k < NUM_NODES; k++)
                    begin
                        case ($urandom_range(7))
                            0: links[k] = COST_INF;
                            1: links[k] = cost_t'($urandom_range(1023, 1000));
                            default: links[k] = cost_t'($urandom_range(60));
                        endcase
                    end
                    program_node(node_t'($urandom_range(NUM_NODES - 1)), links);
                end
            endcase

            // back-to-back items against a long output hold
            if (ph == 1)
            begin
                hold_req = 1'b1;
            end
            burst_left = 0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 3 && n == ITEMS_PER_PHASE / 2)
                begin
                    wait_routes_idle();
                end
                if (ph != 1 && burst_left <= 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                    burst_left = $urandom_range(1, 16);
                end
                op = (n == 0 || $urandom_range(7) == 0) ? OP_INIT : OP_UPDATE;
                for (int k = 0; k < NUM_NODES; k++)
                begin
                    case ($urandom_range(9))
                        0: adv[k] = COST_INF;
                        1: adv[k] = cost_t'($urandom_range(1023));
                        2: adv[k] = cost_t'($urandom_range(1023, 1000));
                        default: adv[k] = cost_t'($urandom_range(40));
                    endcase
                end
                send_item(op, node_t'($urandom_range(NUM_NODES - 1)), adv, 1'b0, 1'b0, '0);
                burst_left--;
            end
        end

        wait_routes_idle();
        if (err_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin : sink
        sink_mode_e mode;
        int         left;
        m_axis_tready = 1'b0;
        mode = SINK_OPEN;
        left = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = sink_mode_e'($urandom_range(2));
                    left = $urandom_range(16, 80);
                end
                left--;
                case (mode)
                    SINK_OPEN: m_axis_tready <= 1'b1;
                    SINK_HALF: m_axis_tready <= 1'($urandom_range(1));
                    default:   m_axis_tready <= ($urandom_range(3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_adverts
        route_pkt_t want;
        cost_vec_t  got_mins;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_mins = m_axis_tdata[43:4];
            if (adverts_due.size() == 0)
            begin
                $error("packet to node %0d with no expected packet", m_axis_tdata[3:2]);
                err_count++;
            end
            else
            begin
                want = adverts_due.pop_front();
                if (m_axis_tdata[1:0] !== want.src)
                begin
                    $error("src_node expected %0d got %0d", want.src, m_axis_tdata[1:0]);
                    err_count++;
                end
                if (m_axis_tdata[3:2] !== want.dst)
                begin
                    $error("dst_node expected %0d got %0d", want.dst, m_axis_tdata[3:2]);
                    err_count++;
                end
                for (int k = 0; k < NUM_NODES; k++)
                begin
                    if (got_mins[k] !== want.mins[k])
                    begin
                        $error("min_cost_%0d expected %0d got %0d", k, want.mins[k],
                               got_mins[k]);
                        err_count++;
                    end
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_packet expected %0d got %0d", want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- sim.f -----
rtl/dvn_pkg.sv
rtl/dvn_lane.sv
rtl/dvn_merge.sv
rtl/dvn_adv.sv
rtl/distance_vector_node_update_unit.sv
test/tb_top.sv
